// ===== rtl/dhtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dhtd_pkg
// Shared types and constants of the dwell hold toggle detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dhtd_pkg;

   // Width of the shared arithmetic unit: holds the sum of two 64-bit squares
   // plus a sign bit for compares done as subtraction.
   localparam int ALU_W   = 66;
   // Multiplier operand width.
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;

   localparam int TIME_W  = 32;
   localparam int DZ_W    = 32;
   localparam int MS_W    = 16;
   localparam int LEVEL_W = 9;

   // Quotient bits of the hold level divide (level never exceeds 256).
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
   localparam logic [1:0] REG_START     = 2'd1;
   localparam logic [1:0] REG_FINISH    = 2'd2;

   localparam logic [15:0] START_RESET  = 16'd300;
   localparam logic [15:0] FINISH_RESET = 16'd1200;
   localparam logic [31:0] DZ_RESET     = 32'd200;

   typedef logic [1:0] alu_op_type;

   localparam alu_op_type OP_ADD = 2'd0;
   localparam alu_op_type OP_SUB = 2'd1;
   localparam alu_op_type OP_MUL = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/dwell_hold_toggle_detector.sv =====
// ----------------------------------------------------------------------------
// dwell_hold_toggle_detector
// Dwell click detector: pointer hold level and pressed toggle per sample.
// ----------------------------------------------------------------------------
// One request is processed at a time through a single shared add/subtract/
// multiply unit stepped by a sequencer; req_stall stays high while a request
// is in work. A moving sample ends after the dead zone compare, a still
// sample that toggles after the finish compare, one that does not pass the
// start threshold after the start compare, and a still sample in the rising
// part after the nine restoring divide steps of the hold level. The next
// request is taken in idle once the result is loaded into the output
// register, so it is taken while the previous result waits on rsp_stall.
`default_nettype none

module dwell_hold_toggle_detector #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_x_pos,
   input  logic signed [COORD_BITS-1:0]         req_y_pos,
   input  logic [dhtd_pkg::TIME_W-1:0]          req_time_ms,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pressed,
   output logic [dhtd_pkg::LEVEL_W-1:0]         rsp_hold_level,
   output logic                                 rsp_toggled,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dhtd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dhtd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dhtd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW  = dhtd_pkg::ALU_W;
   localparam int TW  = dhtd_pkg::TIME_W;
   localparam int MW  = dhtd_pkg::MS_W;
   localparam int LW  = dhtd_pkg::LEVEL_W;
   localparam int PW  = dhtd_pkg::PROD_W;
   localparam int XW  = dhtd_pkg::MUL_W;
   localparam int CW  = dhtd_pkg::DCNT_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DX   = 4'd1;
   localparam logic [3:0] S_DXA  = 4'd2;
   localparam logic [3:0] S_SQX  = 4'd3;
   localparam logic [3:0] S_DY   = 4'd4;
   localparam logic [3:0] S_DYA  = 4'd5;
   localparam logic [3:0] S_SQY  = 4'd6;
   localparam logic [3:0] S_DIST = 4'd7;
   localparam logic [3:0] S_CMP  = 4'd8;
   localparam logic [3:0] S_ELAP = 4'd9;
   localparam logic [3:0] S_CF   = 4'd10;
   localparam logic [3:0] S_CS   = 4'd11;
   localparam logic [3:0] S_NUM  = 4'd12;
   localparam logic [3:0] S_DEN  = 4'd13;
   localparam logic [3:0] S_DIV  = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   localparam logic [CW-1:0] DCNT_FIRST = CW'(dhtd_pkg::DIV_STEPS - 1);

   // control and architectural state
   logic [3:0]                  state_ff, state_in;
   logic [dhtd_pkg::DZ_W-1:0]   dz_ff, dz_in;
   logic [MW-1:0]               start_ff, start_in;
   logic [MW-1:0]               finish_ff, finish_in;
   logic signed [COORD_BITS-1:0] ax_ff, ax_in;
   logic signed [COORD_BITS-1:0] ay_ff, ay_in;
   logic [TW-1:0]               at_ff, at_in;
   logic                        pressed_ff, pressed_in;
   logic [LW-1:0]               level_ff, level_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working registers
   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic [TW-1:0]               t_ff, t_in;
   logic [AW-1:0]               res_ff, res_in;
   logic [XW-1:0]               abs_ff, abs_in;
   logic [PW-1:0]               sq_ff, sq_in;
   logic [TW-1:0]               elap_ff, elap_in;
   logic [MW-1:0]               rem_ff, rem_in;
   logic [MW-1:0]               den_ff, den_in;
   logic                        lsb_ff, lsb_in;
   logic [LW-1:0]               q_ff, q_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        toggled_ff, toggled_in;

   // result register
   logic                        out_pressed_ff, out_pressed_in;
   logic [LW-1:0]               out_level_ff, out_level_in;
   logic                        out_toggled_ff, out_toggled_in;

   dhtd_pkg::alu_op_type        alu_op;
   logic [AW-1:0]               alu_a, alu_b, alu_y;
   logic [MW:0]                 rem2;
   logic                        qbit;
   logic                        csr_wr;

   dhtd_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         dhtd_pkg::REG_DEAD_ZONE: csr_prdata = dz_ff;
         dhtd_pkg::REG_START:     csr_prdata = dhtd_pkg::CSR_DATA_W'(start_ff);
         dhtd_pkg::REG_FINISH:    csr_prdata = dhtd_pkg::CSR_DATA_W'(finish_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // shift in one dividend bit per step: only the first step can carry a one
   assign rem2 = {rem_ff, (cnt_ff == DCNT_FIRST) ? lsb_ff : 1'b0};
   assign qbit = ~alu_y[AW-1];

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pressed    = out_pressed_ff;
   assign rsp_hold_level = out_level_ff;
   assign rsp_toggled    = out_toggled_ff;

   always_comb begin
      state_in       = state_ff;
      dz_in          = dz_ff;
      start_in       = start_ff;
      finish_in      = finish_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      at_in          = at_ff;
      pressed_in     = pressed_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      x_in           = x_ff;
      y_in           = y_ff;
      t_in           = t_ff;
      res_in         = res_ff;
      abs_in         = abs_ff;
      sq_in          = sq_ff;
      elap_in        = elap_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      lsb_in         = lsb_ff;
      q_in           = q_ff;
      cnt_in         = cnt_ff;
      toggled_in     = toggled_ff;
      out_pressed_in = out_pressed_ff;
      out_level_in   = out_level_ff;
      out_toggled_in = out_toggled_ff;
      alu_op         = dhtd_pkg::OP_SUB;
      alu_a          = '0;
      alu_b          = '0;

      if (csr_wr) begin
         case (csr_paddr[3:2])
            dhtd_pkg::REG_DEAD_ZONE: dz_in     = csr_pwdata;
            dhtd_pkg::REG_START:     start_in  = csr_pwdata[MW-1:0];
            dhtd_pkg::REG_FINISH:    finish_in = csr_pwdata[MW-1:0];
            default:                 ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_x_pos;
               y_in     = req_y_pos;
               t_in     = req_time_ms;
               state_in = S_DX;
            end
         end
         S_DX: begin
            alu_a    = AW'(x_ff);
            alu_b    = AW'(ax_ff);
            res_in   = alu_y;
            state_in = S_DXA;
         end
         S_DXA: begin
            alu_b    = res_ff;
            abs_in   = res_ff[AW-1] ? alu_y[XW-1:0] : res_ff[XW-1:0];
            state_in = S_SQX;
         end
         S_SQX: begin
            alu_op   = dhtd_pkg::OP_MUL;
            alu_a    = AW'(abs_ff);
            alu_b    = AW'(abs_ff);
            sq_in    = alu_y[PW-1:0];
            state_in = S_DY;
         end
         S_DY: begin
            alu_a    = AW'(y_ff);
            alu_b    = AW'(ay_ff);
            res_in   = alu_y;
            state_in = S_DYA;
         end
         S_DYA: begin
            alu_b    = res_ff;
            abs_in   = res_ff[AW-1] ? alu_y[XW-1:0] : res_ff[XW-1:0];
            state_in = S_SQY;
         end
         S_SQY: begin
            alu_op   = dhtd_pkg::OP_MUL;
            alu_a    = AW'(abs_ff);
            alu_b    = AW'(abs_ff);
            res_in   = alu_y;
            state_in = S_DIST;
         end
         S_DIST: begin
            alu_op   = dhtd_pkg::OP_ADD;
            alu_a    = AW'(sq_ff);
            alu_b    = res_ff;
            res_in   = alu_y;
            state_in = S_CMP;
         end
         S_CMP: begin
            alu_a = res_ff;
            alu_b = AW'(dz_ff);
            if (alu_y[AW-1]) begin
               state_in = S_ELAP;
            end else begin
               // moving: re-anchor, keep the level
               ax_in      = x_ff;
               ay_in      = y_ff;
               at_in      = t_ff;
               toggled_in = 1'b0;
               state_in   = S_OUT;
            end
         end
         S_ELAP: begin
            alu_a    = AW'(t_ff);
            alu_b    = AW'(at_ff);
            elap_in  = alu_y[TW-1:0];
            state_in = S_CF;
         end
         S_CF: begin
            alu_a = AW'(finish_ff);
            alu_b = AW'(elap_ff);
            if (alu_y[AW-1]) begin
               ax_in      = x_ff;
               ay_in      = y_ff;
               at_in      = t_ff;
               pressed_in = ~pressed_ff;
               level_in   = '0;
               toggled_in = 1'b1;
               state_in   = S_OUT;
            end else begin
               state_in = S_CS;
            end
         end
         S_CS: begin
            alu_a      = AW'(start_ff);
            alu_b      = AW'(elap_ff);
            toggled_in = 1'b0;
            if (!alu_y[AW-1]) begin
               level_in = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            // elapsed - start fits in 16 bits here since elapsed <= finish
            alu_a    = AW'(elap_ff);
            alu_b    = AW'(start_ff);
            rem_in   = {1'b0, alu_y[MW-1:1]};
            lsb_in   = alu_y[0];
            state_in = S_DEN;
         end
         S_DEN: begin
            alu_a    = AW'(finish_ff);
            alu_b    = AW'(start_ff);
            den_in   = alu_y[MW-1:0];
            q_in     = '0;
            cnt_in   = DCNT_FIRST;
            state_in = S_DIV;
         end
         S_DIV: begin
            alu_a  = AW'(rem2);
            alu_b  = AW'(den_ff);
            rem_in = qbit ? alu_y[MW-1:0] : rem2[MW-1:0];
            q_in   = {q_ff[LW-2:0], qbit};
            if (cnt_ff == '0) begin
               level_in = {q_ff[LW-2:0], qbit};
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               out_pressed_in = pressed_ff;
               out_level_in   = level_ff;
               out_toggled_in = toggled_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dz_ff        <= dhtd_pkg::DZ_RESET;
         start_ff     <= dhtd_pkg::START_RESET;
         finish_ff    <= dhtd_pkg::FINISH_RESET;
         ax_ff        <= '0;
         ay_ff        <= '0;
         at_ff        <= '0;
         pressed_ff   <= 1'b0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dz_ff        <= dz_in;
         start_ff     <= start_in;
         finish_ff    <= finish_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         at_ff        <= at_in;
         pressed_ff   <= pressed_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      t_ff           <= t_in;
      res_ff         <= res_in;
      abs_ff         <= abs_in;
      sq_ff          <= sq_in;
      elap_ff        <= elap_in;
      rem_ff         <= rem_in;
      den_ff         <= den_in;
      lsb_ff         <= lsb_in;
      q_ff           <= q_in;
      cnt_ff         <= cnt_in;
      toggled_ff     <= toggled_in;
      out_pressed_ff <= out_pressed_in;
      out_level_ff   <= out_level_in;
      out_toggled_ff <= out_toggled_in;
   end

   a_toggle_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_toggled |-> rsp_hold_level == '0)
      else $error("toggle result carries a nonzero hold level");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hold_level <= LW'(256))
      else $error("hold level above full scale");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DX && req_stall)
      else $error("accepted request did not start the sequence");

   a_pressed_only_on_toggle: assert property (@(posedge clock) disable iff (reset)
      !$stable(pressed_ff) |-> $past(reset) || $past(state_ff) == S_CF)
      else $error("pressed state changed outside the toggle step");

endmodule

`default_nettype wire

// ===== rtl/dhtd_alu.sv =====
// ----------------------------------------------------------------------------
// dhtd_alu
// Shared arithmetic unit: add, subtract or 32x32 multiply, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtd_alu (
   input  dhtd_pkg::alu_op_type         op,
   input  logic [dhtd_pkg::ALU_W-1:0]   a,
   input  logic [dhtd_pkg::ALU_W-1:0]   b,
   output logic [dhtd_pkg::ALU_W-1:0]   y
);

   localparam int AW = dhtd_pkg::ALU_W;

   logic [dhtd_pkg::PROD_W-1:0] prod;

   assign prod = a[dhtd_pkg::MUL_W-1:0] * b[dhtd_pkg::MUL_W-1:0];

   always_comb begin
      case (op)
         dhtd_pkg::OP_ADD: y = a + b;
         dhtd_pkg::OP_SUB: y = a - b;
         dhtd_pkg::OP_MUL: y = AW'(prod);
         default:          y = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dwell hold toggle detector: a short table of
// hand-picked pointer samples and register writes, then random hold and move
// sequences under eight register settings and four idle/stall patterns. Every
// result is checked against a cycle-free model of the anchor, level and
// pressed state kept in the bench, or against a directed row's typed result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COORD_W = 16;
   localparam int unsigned RUN_LIMIT = 1_000_000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 229;
   localparam int PLAN_ROWS = 29;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic                          pressed;
      logic [dhtd_pkg::LEVEL_W-1:0]  level;
      logic                          toggled;
   } outcome_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [1:0]                     idx;
      logic [31:0]                    wdata;
      logic signed [COORD_W-1:0]      x;
      logic signed [COORD_W-1:0]      y;
      logic [dhtd_pkg::TIME_W-1:0]    t;
      logic                           typed;
      outcome_type                    want;
   } row_type;

   // Directed part: reset thresholds first, then out-of-order thresholds and
   // the register extremes. Rows with typed = 1 carry a hand-computed result.
   localparam row_type PLAN [0:PLAN_ROWS-1] = '{
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd0,    1'b1, '{1'b0, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd300,  1'b1, '{1'b0, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd301,  1'b0, '{1'b0, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd750,  1'b1, '{1'b0, 9'd128, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd1200, 1'b1, '{1'b0, 9'd256, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'd1201, 1'b1, '{1'b1, 9'd0,   1'b1}},
      // squared distance exactly on the dead zone counts as moving
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh000A, 16'sh000A, 32'd1500, 1'b1, '{1'b1, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0014, 16'sh0013, 32'd2000, 1'b0, '{1'b0, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh8000, 16'sh8000, 32'd2100, 1'b0, '{1'b0, 9'd0,   1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 32'd2200, 1'b0, '{1'b0, 9'd0,   1'b0}},
      // timestamp one behind the anchor reads as a huge elapsed time
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 32'd2199, 1'b1, '{1'b0, 9'd0,   1'b1}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'shFFFF, 16'shFFFF, 32'hFFFF_FF00, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'shFFFF, 16'shFFFF, 32'h0000_0100, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_START, 32'd500, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_FINISH, 32'd500, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'shFFFF, 16'shFFFF, 32'h0000_0105, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_FINISH, 32'd100, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'shFFFF, 16'shFFFF, 32'h0000_035D, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_DEAD_ZONE, 32'd0, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'shFFFF, 16'shFFFF, 32'h0000_0400, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_DEAD_ZONE, 32'hFFFF_FFFF, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_START, 32'd0, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_FINISH, 32'd65535, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 32'h0000_0500, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh8000, 16'sh8000, 32'h0000_0600, 1'b0, '{1'b0, 9'd0, 1'b0}},
      // a write to an unmapped register leaves the thresholds alone
      '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 16'sh0, 16'sh0, 32'd0, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'h0001_0500, 1'b0, '{1'b0, 9'd0, 1'b0}},
      '{ROW_WRITE, dhtd_pkg::REG_START, 32'd65535, 16'sh0, 16'sh0, 32'd0, 1'b0,
        '{1'b0, 9'd0, 1'b0}},
      '{ROW_SAMPLE, 2'd0, 32'd0, 16'sh0000, 16'sh0000, 32'h0002_0000, 1'b0, '{1'b0, 9'd0, 1'b0}}
   };

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [COORD_W-1:0]           req_x_pos = '0;
   logic signed [COORD_W-1:0]           req_y_pos = '0;
   logic [dhtd_pkg::TIME_W-1:0]         req_time_ms = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_pressed;
   logic [dhtd_pkg::LEVEL_W-1:0]        rsp_hold_level;
   logic                                rsp_toggled;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [dhtd_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [dhtd_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [dhtd_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   // bench copy of the block's registers and state
   logic [dhtd_pkg::DZ_W-1:0]           cfg_dead_zone = dhtd_pkg::DZ_RESET;
   logic [dhtd_pkg::MS_W-1:0]           cfg_start = dhtd_pkg::START_RESET;
   logic [dhtd_pkg::MS_W-1:0]           cfg_finish = dhtd_pkg::FINISH_RESET;
   logic signed [COORD_W-1:0]           hold_x = '0;
   logic signed [COORD_W-1:0]           hold_y = '0;
   logic [dhtd_pkg::TIME_W-1:0]         hold_t = '0;
   logic                                pressed_now = 1'b0;
   logic [dhtd_pkg::LEVEL_W-1:0]        level_now = '0;

   outcome_type                   sample_outcomes[$];
   outcome_type                   oldest;
   int unsigned                   idle_pct = 0;
   int unsigned                   stall_pct = 0;
   int unsigned                   cycles_run = 0;
   int unsigned                   error_count = 0;
   int unsigned                   samples_sent = 0;
   int unsigned                   settings_used = 1;
   int unsigned                   toggles_seen = 0;
   int unsigned                   ramp_seen = 0;

   dwell_hold_toggle_detector #(
      .COORD_BITS(COORD_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_time_ms    (req_time_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pressed    (rsp_pressed),
      .rsp_hold_level (rsp_hold_level),
      .rsp_toggled    (rsp_toggled),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Advance the dwell state by one sample and return what the block reports.
   function automatic outcome_type step_dwell(logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              logic [dhtd_pkg::TIME_W-1:0] t);
      longint dx, dy, dist_sq;
      logic [dhtd_pkg::TIME_W-1:0] elapsed;
      logic [63:0] num, den;
      outcome_type res;
      dx = x - hold_x;
      dy = y - hold_y;
      dist_sq = dx * dx + dy * dy;
      res.toggled = 1'b0;
      if (dist_sq < longint'(cfg_dead_zone)) begin
         elapsed = t - hold_t;
         level_now = '0;
         if (elapsed > cfg_start && elapsed <= cfg_finish) begin
            num = {32'd0, elapsed - {16'd0, cfg_start}} << 8;
            den = {48'd0, cfg_finish - cfg_start};
            level_now = dhtd_pkg::LEVEL_W'(num / den);
         end
         if (elapsed > cfg_finish) begin
            hold_x = x;
            hold_y = y;
            hold_t = t;
            pressed_now = ~pressed_now;
            level_now = '0;
            res.toggled = 1'b1;
         end
      end else begin
         // moving: re-anchor, keep the level
         hold_x = x;
         hold_y = y;
         hold_t = t;
      end
      res.pressed = pressed_now;
      res.level = level_now;
      return res;
   endfunction

   task automatic offer_sample(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic [dhtd_pkg::TIME_W-1:0] t,
                               input logic typed, input outcome_type want);
      outcome_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_x_pos <= x;
      req_y_pos <= y;
      req_time_ms <= t;
      do @(posedge clock); while (req_stall);
      predicted = step_dwell(x, y, t);
      sample_outcomes.push_back(typed ? want : predicted);
      samples_sent++;
   endtask

   // Drop valid and wait until every pending result has come back.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sample_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want, mask;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mask = '0;
      want = '0;
      case (idx)
         dhtd_pkg::REG_DEAD_ZONE: begin
            cfg_dead_zone = value;
            want = value;
            mask = '1;
         end
         dhtd_pkg::REG_START: begin
            cfg_start = value[dhtd_pkg::MS_W-1:0];
            want = {16'd0, value[dhtd_pkg::MS_W-1:0]};
            mask = 32'h0000_FFFF;
         end
         dhtd_pkg::REG_FINISH: begin
            cfg_finish = value[dhtd_pkg::MS_W-1:0];
            want = {16'd0, value[dhtd_pkg::MS_W-1:0]};
            mask = 32'h0000_FFFF;
         end
         default: begin
         end
      endcase
      if (mask != '0) begin
         // read back what was just written
         @(negedge clock);
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if ((csr_prdata & mask) !== want) begin
            flag_error($sformatf("ERROR: register %0d read back 0x%08h, expected 0x%08h",
                                 idx, csr_prdata & mask, want));
         end
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_outcomes.size() == 0) begin
            flag_error($sformatf("ERROR: unrequested result pressed=%0b level=%0d toggled=%0b",
                                 rsp_pressed, rsp_hold_level, rsp_toggled));
         end else begin
            oldest = sample_outcomes.pop_front();
            if (rsp_pressed !== oldest.pressed || rsp_hold_level !== oldest.level ||
                rsp_toggled !== oldest.toggled) begin
               flag_error($sformatf(
                  "ERROR: pressed/level/toggled expected %0b/%0d/%0b, got %0b/%0d/%0b",
                  oldest.pressed, oldest.level, oldest.toggled,
                  rsp_pressed, rsp_hold_level, rsp_toggled));
            end
            if (rsp_toggled === 1'b1) toggles_seen++;
            if (rsp_hold_level != '0) ramp_seen++;
         end
      end
   end

   initial begin
      wait (cycles_run >= RUN_LIMIT);
      $display("Timeout after %0d cycles", cycles_run);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      row_type row;
      logic signed [COORD_W-1:0] x, y;
      logic [dhtd_pkg::TIME_W-1:0] t, cur_t;
      logic [31:0] dz;
      logic [15:0] st, fi;
      int j, pick;
      int unsigned span, directed;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = PLAN[r];
         if (row.kind == ROW_WRITE) begin
            settle_block();
            write_reg(row.idx, row.wdata);
            settings_used++;
         end else begin
            offer_sample(row.x, row.y, row.t, row.typed, row.want);
         end
      end
      directed = samples_sent;

      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         case (p)
            0: begin
               dz = dhtd_pkg::DZ_RESET;
               st = dhtd_pkg::START_RESET;
               fi = dhtd_pkg::FINISH_RESET;
            end
            1: begin
               dz = '0;
               st = 16'($urandom_range(0, 2000));
               fi = 16'($urandom_range(0, 4000));
            end
            2: begin dz = '1; st = '0; fi = '1; end
            3: begin dz = $urandom_range(50, 5000); st = '1; fi = '1; end
            4: begin
               dz = $urandom_range(100, 3000);
               st = 16'($urandom_range(1000, 5000));
               fi = 16'($urandom_range(0, 999));
            end
            5: begin dz = $urandom_range(1, 500); st = '0; fi = '0; end
            6: begin
               dz = $urandom_range(0, 20000);
               st = 16'($urandom_range(0, 300));
               fi = st + 16'($urandom_range(1, 1000));
            end
            default: begin
               dz = $urandom;
               st = 16'($urandom_range(0, 65535));
               fi = 16'($urandom_range(0, 65535));
            end
         endcase
         write_reg(dhtd_pkg::REG_DEAD_ZONE, dz);
         write_reg(dhtd_pkg::REG_START, {16'd0, st});
         write_reg(dhtd_pkg::REG_FINISH, {16'd0, fi});
         settings_used++;
         case (p % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 48; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 48; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         cur_t = (p % 2) ? dhtd_pkg::TIME_W'($urandom) : hold_t;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            span = ((cfg_start > cfg_finish) ? cfg_start : cfg_finish) / 3 + 8;
            if (cfg_dead_zone >= 20000) j = 90;
            else if (cfg_dead_zone >= 200) j = 7;
            else if (cfg_dead_zone >= 8) j = 1;
            else j = 0;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // hold still around the anchor while time runs on
               x = COORD_W'(int'(hold_x) + int'($urandom_range(0, 2 * j)) - j);
               y = COORD_W'(int'(hold_y) + int'($urandom_range(0, 2 * j)) - j);
               cur_t += $urandom_range(0, span);
            end else if (pick < 82) begin
               x = COORD_W'(int'(hold_x) + int'($urandom_range(0, 80)) - 40);
               y = COORD_W'(int'(hold_y) + int'($urandom_range(0, 80)) - 40);
               cur_t += $urandom_range(0, span / 4 + 1);
            end else if (pick < 90) begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
               cur_t += $urandom_range(0, span / 4 + 1);
            end else if (pick < 95) begin
               // jump the clock anywhere, backwards included
               x = hold_x;
               y = hold_y;
               cur_t = $urandom;
            end else begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
               cur_t = $urandom;
            end
            t = cur_t;
            offer_sample(x, y, t, 1'b0, '0);
         end
      end

      settle_block();
      repeat (40) @(posedge clock);
      $display("Checked %0d samples, %0d of them hand-picked, over %0d register settings",
               samples_sent, directed, settings_used);
      $display("Saw %0d toggles and %0d results on the rising part of the hold",
               toggles_seen, ramp_seen);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dhtd_pkg.sv
rtl/dhtd_alu.sv
rtl/dwell_hold_toggle_detector.sv
test/tb_top.sv
